// File: sv/hec_pkg.sv
// ----------------------------------------------------------------------------
// hec_pkg
// Shared types and constants for the Huffman escape encoder: item and
// result formats, opcodes, field widths and the register map.
// ----------------------------------------------------------------------------
package hec_pkg;

    localparam int MAX_CODE_LEN = 12;
    localparam int TABLE_DEPTH  = 1024;
    localparam int SYM_W        = 10;
    localparam int CODE_W       = 12;
    localparam int LEN_W        = 4;
    localparam int ESC_REG_W    = 4;
    localparam int ESC_W_MAX    = 10;           // min(10, 24 - MAX_CODE_LEN)
    localparam int ADD_W        = MAX_CODE_LEN + ESC_W_MAX;  // bits added per symbol
    localparam int OFF_W        = 3;
    localparam int PEND_W       = 7;
    localparam int ACC_W        = PEND_W + ADD_W;
    localparam int POS_W        = 5;            // holds 7 + 22
    localparam int NBYTE_W      = 2;            // up to 3 bytes per item
    localparam int TOTAL_W      = 32;
    localparam int ESC_RESET    = 8;

    // APB register map
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;
    localparam logic REG_ESCAPE_BITS = 1'b0;   // word index, paddr[2]

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] entry_code;
        logic [LEN_W-1:0]  entry_length;
    } item_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               is_final;
        logic [TOTAL_W-1:0] total_bits;
        logic               last;
    } result_t;

endpackage

// File: sv/huffman_escape_encoder_core.sv
// ----------------------------------------------------------------------------
// huffman_escape_encoder_core
// Table-driven Huffman bit packer with escape codes and byte output.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): load a codebook entry, encode
//   a symbol, or flush the block. An item is taken on valid & ready.
//   result channel (result_valid/result_ready/result): one packed byte per
//   result; an encode gives 0..3 bytes, a flush gives exactly one final result
//   with the zero-padded partial byte and the saturating bit total. The
//   last flag marks the final result of each input item.
//   APB port: register 0 (address 0) holds escape_symbol_bits, reset 8.
//   Pipeline: codebook read stage, then pack stage into the result register.
//   Throughput: one item per cycle while each item gives at most one
//   result and result_ready stays high; an item giving more bytes holds
//   the result register until all are taken, one byte per cycle.
//   Reset clears the packer (pending bits, offset, total) and the pipeline
//   valids; the codebook RAM is not cleared and must be loaded before use.
//   A stalled receiver holds the result register; the input stage fills up
//   behind it and item_ready drops, nothing is lost.
// ----------------------------------------------------------------------------
module huffman_escape_encoder_core (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        item_valid,
    output logic                        item_ready,
    input  hec_pkg::item_t              item,

    output logic                        result_valid,
    input  logic                        result_ready,
    output hec_pkg::result_t            result,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hec_pkg::ADDR_W-1:0]  paddr,
    input  logic [hec_pkg::DATA_W-1:0]  pwdata,
    output logic [hec_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    // ---------------- configuration register ----------------
    logic [hec_pkg::ESC_REG_W-1:0] esc_bits_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_bits_reg <= hec_pkg::ESC_REG_W'(hec_pkg::ESC_RESET);
        end
        else if (psel && penable && pwrite && (paddr[2] == hec_pkg::REG_ESCAPE_BITS))
        begin
            esc_bits_reg <= pwdata[hec_pkg::ESC_REG_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == hec_pkg::REG_ESCAPE_BITS)
        begin
            prdata = hec_pkg::DATA_W'(esc_bits_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // ---------------- stage 1: codebook RAM ----------------
    // Load writes and encode reads both happen at the accept edge, so
    // codebook order matches item order.
    logic [hec_pkg::CODE_W+hec_pkg::LEN_W-1:0] book_mem [hec_pkg::TABLE_DEPTH];

    logic                         s1_valid_reg;
    logic [1:0]                   s1_op_reg;
    logic [hec_pkg::SYM_W-1:0]    s1_sym_reg;
    logic [hec_pkg::CODE_W-1:0]   s1_code_reg;
    logic [hec_pkg::LEN_W-1:0]    s1_len_reg;
    logic [hec_pkg::LEN_W-1:0]    load_len;

    logic take;
    logic s2_take;
    logic grp_free;

    assign take       = item_valid && item_ready;
    assign item_ready = !s1_valid_reg || s2_take;

    // lengths beyond the maximum become escapes
    assign load_len = (item.entry_length > hec_pkg::LEN_W'(hec_pkg::MAX_CODE_LEN)) ?
                      hec_pkg::LEN_W'(hec_pkg::MAX_CODE_LEN) : item.entry_length;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (item.opcode == hec_pkg::OP_LOAD)
            begin
                book_mem[item.symbol] <= {item.entry_code, load_len};
            end
            {s1_code_reg, s1_len_reg} <= book_mem[item.symbol];
            s1_op_reg  <= item.opcode;
            s1_sym_reg <= item.symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    // ---------------- stage 2: bit packer ----------------
    logic [hec_pkg::PEND_W-1:0]  pend_reg,  pend_next;
    logic [hec_pkg::OFF_W-1:0]   off_reg,   off_next;
    logic [hec_pkg::TOTAL_W-1:0] total_reg, total_next;

    // result group: up to three bytes drained one per cycle while result_ready is high
    logic                         grp_valid_reg,  grp_valid_next;
    logic [23:0]                  grp_bytes_reg,  grp_bytes_next;
    logic [hec_pkg::NBYTE_W-1:0]  grp_cnt_reg,    grp_cnt_next;
    logic [hec_pkg::NBYTE_W-1:0]  grp_idx_reg,    grp_idx_next;
    logic                         grp_final_reg,  grp_final_next;
    logic [hec_pkg::TOTAL_W-1:0]  grp_total_reg,  grp_total_next;

    logic                         grp_last;
    logic                         res_take;

    logic                         is_esc;
    logic [hec_pkg::CODE_W-1:0]   code_bits;
    logic [hec_pkg::LEN_W-1:0]    esc_w;
    logic [hec_pkg::SYM_W-1:0]    raw_sym;
    logic [hec_pkg::ADD_W-1:0]    add_bits;
    logic [hec_pkg::POS_W-1:0]    n_bits;
    logic [hec_pkg::PEND_W-1:0]   pend_live;
    logic [hec_pkg::ACC_W-1:0]    acc;
    logic [hec_pkg::POS_W-1:0]    pos;
    logic [hec_pkg::NBYTE_W-1:0]  nbytes;
    logic [hec_pkg::OFF_W-1:0]    pos_off;
    logic [hec_pkg::ACC_W-1:0]    acc_rest;
    logic [hec_pkg::TOTAL_W:0]    total_sum;

    assign grp_last = (grp_idx_reg == grp_cnt_reg - hec_pkg::NBYTE_W'(1));
    assign res_take = result_valid && result_ready;
    assign grp_free = !grp_valid_reg || (res_take && grp_last);
    assign s2_take  = s1_valid_reg && grp_free;

    always_comb
    begin
        is_esc    = (s1_len_reg == hec_pkg::LEN_W'(hec_pkg::MAX_CODE_LEN));
        code_bits = s1_code_reg &
                    hec_pkg::CODE_W'((17'd1 << s1_len_reg) - 17'd1);
        esc_w     = (esc_bits_reg > hec_pkg::LEN_W'(hec_pkg::ESC_W_MAX)) ?
                    hec_pkg::LEN_W'(hec_pkg::ESC_W_MAX) : esc_bits_reg;
        raw_sym   = s1_sym_reg & hec_pkg::SYM_W'((17'd1 << esc_w) - 17'd1);

        add_bits  = hec_pkg::ADD_W'(code_bits);
        n_bits    = hec_pkg::POS_W'(s1_len_reg);
        if (is_esc)
        begin
            add_bits = add_bits | (hec_pkg::ADD_W'(raw_sym) << hec_pkg::MAX_CODE_LEN);
            n_bits   = n_bits + hec_pkg::POS_W'(esc_w);
        end

        pend_live = pend_reg & hec_pkg::PEND_W'((8'd1 << off_reg) - 8'd1);
        acc       = hec_pkg::ACC_W'(pend_live) | (hec_pkg::ACC_W'(add_bits) << off_reg);
        pos       = hec_pkg::POS_W'(off_reg) + n_bits;
        nbytes    = pos[4:3];
        pos_off   = pos[2:0];
        acc_rest  = acc >> {nbytes, 3'b000};
        total_sum = {1'b0, total_reg} + (hec_pkg::TOTAL_W+1)'(n_bits);
    end

    always_comb
    begin
        pend_next      = pend_reg;
        off_next       = off_reg;
        total_next     = total_reg;
        grp_valid_next = grp_valid_reg;
        grp_bytes_next = grp_bytes_reg;
        grp_cnt_next   = grp_cnt_reg;
        grp_idx_next   = grp_idx_reg;
        grp_final_next = grp_final_reg;
        grp_total_next = grp_total_reg;

        if (res_take && !grp_last)
        begin
            grp_idx_next = grp_idx_reg + hec_pkg::NBYTE_W'(1);
        end
        else if (res_take)
        begin
            grp_valid_next = 1'b0;
        end

        if (s2_take)
        begin
            case (s1_op_reg)
                hec_pkg::OP_ENCODE:
                begin
                    off_next   = pos_off;
                    pend_next  = acc_rest[hec_pkg::PEND_W-1:0] &
                                 hec_pkg::PEND_W'((8'd1 << pos_off) - 8'd1);
                    total_next = total_sum[hec_pkg::TOTAL_W] ? '1 :
                                 total_sum[hec_pkg::TOTAL_W-1:0];
                    grp_valid_next = (nbytes != '0);
                    grp_bytes_next = acc[23:0];
                    grp_cnt_next   = nbytes;
                    grp_idx_next   = '0;
                    grp_final_next = 1'b0;
                    grp_total_next = '0;
                end
                hec_pkg::OP_FLUSH:
                begin
                    pend_next      = '0;
                    off_next       = '0;
                    total_next     = '0;
                    grp_valid_next = 1'b1;
                    grp_bytes_next = {16'd0, 1'b0, pend_live};
                    grp_cnt_next   = hec_pkg::NBYTE_W'(1);
                    grp_idx_next   = '0;
                    grp_final_next = 1'b1;
                    grp_total_next = total_reg;
                end
                default:
                begin
                    // load already done in stage 1; unused opcode does nothing
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            off_reg       <= '0;
            total_reg     <= '0;
            grp_valid_reg <= 1'b0;
            grp_cnt_reg   <= '0;
            grp_idx_reg   <= '0;
        end
        else
        begin
            pend_reg      <= pend_next;
            off_reg       <= off_next;
            total_reg     <= total_next;
            grp_valid_reg <= grp_valid_next;
            grp_cnt_reg   <= grp_cnt_next;
            grp_idx_reg   <= grp_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_bytes_reg <= grp_bytes_next;
        grp_final_reg <= grp_final_next;
        grp_total_reg <= grp_total_next;
    end

    // ---------------- result port ----------------
    assign result_valid = grp_valid_reg;

    always_comb
    begin
        case (grp_idx_reg)
            2'd0:    result.out_byte = grp_bytes_reg[7:0];
            2'd1:    result.out_byte = grp_bytes_reg[15:8];
            default: result.out_byte = grp_bytes_reg[23:16];
        endcase
        result.is_final   = grp_final_reg;
        result.total_bits = grp_total_reg;
        result.last       = grp_last;
    end

endmodule
